@@ src/msp_pkg.sv @@
// ----------------------------------------------------------------------------
// msp_pkg: shared types and constants for the motor speed PWM integrator
// Register indexes, reset values, datapath widths, controller states and
// the command bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package msp_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_CONTROL_FREQUENCY   = 2'd0;
	localparam logic [1:0] REG_PULSES_PER_ROTATION = 2'd1;
	localparam logic [1:0] REG_CHANNEL_COUNT       = 2'd2;
	localparam logic [1:0] REG_SPEED_GAIN          = 2'd3;

	localparam logic [13:0] FREQ_RESET  = 14'd100;
	localparam logic [15:0] PPR_RESET   = 16'd374;
	localparam logic [2:0]  CHAN_RESET  = 3'd2;
	localparam logic [9:0]  GAIN_RESET  = 10'd128;

	localparam int ACC_W    = 18;
	localparam int NUM_W    = 37;
	localparam int DEN_W    = 19;
	localparam int QUO_W    = 16;
	localparam int SUM_W    = 29;

	// 512.0 in Q10.8
	localparam logic [ACC_W-1:0] ACC_MAX = 18'd131072;
	localparam logic [QUO_W-1:0] RPM_MAX = 16'hFFFF;
	localparam logic [3:0]       DIV_LAST_BIT = 4'd15;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SCALE,
		ST_CHECK,
		ST_DIV,
		ST_ERR,
		ST_ACC,
		ST_EMIT
	} msp_state_t;

	typedef struct packed {
		logic load_in;
		logic mul;
		logic scale;
		logic check;
		logic div_step;
		logic err_mul;
		logic acc_upd;
		logic out_load;
	} msp_cmd_t;

endpackage

`default_nettype wire

@@ src/msp_ctrl.sv @@
// ----------------------------------------------------------------------------
// msp_ctrl: sequencer for one control period
// Steps the datapath through multiply, scale, range check, sixteen divide
// iterations, gain multiply and accumulate, then hands off the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msp_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output msp_pkg::msp_cmd_t     cmd
);

	msp_pkg::msp_state_t state_q, state_next;
	logic [3:0] bit_cnt_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_next = state_q;
		case (state_q)
			msp_pkg::ST_IDLE:  if (in_valid) state_next = msp_pkg::ST_MUL;
			msp_pkg::ST_MUL:   state_next = msp_pkg::ST_SCALE;
			msp_pkg::ST_SCALE: state_next = msp_pkg::ST_CHECK;
			msp_pkg::ST_CHECK: state_next = msp_pkg::ST_DIV;
			msp_pkg::ST_DIV:   if (bit_cnt_q == 4'd0) state_next = msp_pkg::ST_ERR;
			msp_pkg::ST_ERR:   state_next = msp_pkg::ST_ACC;
			msp_pkg::ST_ACC:   state_next = msp_pkg::ST_EMIT;
			msp_pkg::ST_EMIT:  if (out_free) state_next = msp_pkg::ST_IDLE;
			default:           state_next = msp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			msp_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			msp_pkg::ST_MUL:   cmd.mul      = 1'b1;
			msp_pkg::ST_SCALE: cmd.scale    = 1'b1;
			msp_pkg::ST_CHECK: cmd.check    = 1'b1;
			msp_pkg::ST_DIV:   cmd.div_step = 1'b1;
			msp_pkg::ST_ERR:   cmd.err_mul  = 1'b1;
			msp_pkg::ST_ACC:   cmd.acc_upd  = 1'b1;
			msp_pkg::ST_EMIT:  cmd.out_load = out_free;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= msp_pkg::ST_IDLE;
			bit_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.check)
				bit_cnt_q <= msp_pkg::DIV_LAST_BIT;
			else if (cmd.div_step)
				bit_cnt_q <= bit_cnt_q - 4'd1;
			// hold the result until taken; a new load replaces a taken one
			out_valid_q <= cmd.out_load || (out_valid_q && !out_ready);
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ src/msp_dpath.sv @@
// ----------------------------------------------------------------------------
// msp_dpath: speed measurement and PWM accumulator datapath
// Forms pulses*120*frequency, divides by pulses_per_rotation*channels one
// quotient bit per cycle with saturation, then applies the gain step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msp_dpath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire msp_pkg::msp_cmd_t  cmd,
	input  wire logic [15:0]        pulse_count,
	input  wire logic signed [15:0] target_rpm,
	input  wire logic [13:0]        control_frequency,
	input  wire logic [15:0]        pulses_per_rotation,
	input  wire logic [2:0]         channel_count,
	input  wire logic [9:0]         speed_gain,
	output logic [9:0]              pwm_duty,
	output logic [15:0]             measured_rpm
);

	localparam int NW = msp_pkg::NUM_W;
	localparam int DW = msp_pkg::DEN_W;
	localparam int QW = msp_pkg::QUO_W;
	localparam int AW = msp_pkg::ACC_W;
	localparam int SW = msp_pkg::SUM_W;

	logic [15:0]           pulses_q;
	logic signed [15:0]    target_q;
	logic [29:0]           prod_q;
	logic [NW-1:0]         num_q;
	logic [DW-1:0]         den_q;
	logic                  sat_q;
	logic [DW:0]           part_q;
	logic [QW-1:0]         low_q;
	logic [QW-1:0]         quo_q;
	logic signed [SW-1:0]  step_q;
	logic [AW-1:0]         acc_q;
	logic [9:0]            duty_q;
	logic [15:0]           rpm_out_q;

	logic [NW-1:0]         num_next;
	logic [DW:0]           trial;
	logic                  trial_ge;
	logic [QW-1:0]         rpm;
	logic signed [17:0]    err;
	logic signed [SW-1:0]  sum;
	logic [AW-1:0]         acc_next;

	// times 120 = times 128 minus times 8
	assign num_next = {prod_q, 7'd0} - {4'd0, prod_q, 3'd0};

	assign trial    = {part_q[DW-1:0], low_q[QW-1]};
	assign trial_ge = trial >= {1'b0, den_q};

	assign rpm = sat_q ? msp_pkg::RPM_MAX : quo_q;
	assign err = $signed({{2{target_q[15]}}, target_q}) - $signed({2'b00, rpm});

	assign sum = $signed({{(SW-AW){1'b0}}, acc_q}) + step_q;

	always_comb begin
		if (sum < 0)
			acc_next = '0;
		else if (sum > $signed({{(SW-AW){1'b0}}, msp_pkg::ACC_MAX}))
			acc_next = msp_pkg::ACC_MAX;
		else
			acc_next = sum[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			pulses_q <= pulse_count;
			target_q <= target_rpm;
		end
		if (cmd.mul)
			prod_q <= 30'(pulses_q) * 30'(control_frequency);
		if (cmd.scale) begin
			num_q <= num_next;
			den_q <= DW'(pulses_per_rotation) * DW'(channel_count);
		end
		if (cmd.check) begin
			// quotient above 16 bits or zero divisor saturates
			sat_q  <= (den_q == '0) || (num_q[NW-1:QW] >= {2'b00, den_q});
			part_q <= num_q[QW+DW:QW];
			low_q  <= num_q[QW-1:0];
			quo_q  <= '0;
		end
		if (cmd.div_step) begin
			part_q <= trial_ge ? (trial - {1'b0, den_q}) : trial;
			low_q  <= {low_q[QW-2:0], 1'b0};
			quo_q  <= {quo_q[QW-2:0], trial_ge};
		end
		if (cmd.err_mul)
			step_q <= SW'($signed({1'b0, speed_gain})) * SW'(err);
		if (cmd.out_load) begin
			duty_q    <= acc_q[AW-1:8];
			rpm_out_q <= rpm;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			acc_q <= '0;
		else if (cmd.acc_upd)
			acc_q <= acc_next;
	end

	assign pwm_duty     = duty_q;
	assign measured_rpm = rpm_out_q;

endmodule

`default_nettype wire

@@ src/motor_speed_pwm_integrator.sv @@
// ----------------------------------------------------------------------------
// motor_speed_pwm_integrator: incremental proportional speed controller
// Measures rpm from an encoder pulse count, applies a proportional gain to
// the speed error and integrates it into a clamped PWM duty value.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | pulse_count[15:0], target_rpm[15:0] signed
//  out     | out_valid/ out_ready | pwm_duty[9:0], measured_rpm[15:0]
//  cfg     | cfg_we               | cfg_index[1:0], cfg_wdata[15:0]
//
// A request passes through multiply, scale, range check, the 16 iterations
// of the bit-serial rpm divider, gain multiply, accumulate and emit. in_ready
// is high only while the sequencer is idle, so a new request is taken only
// once the last one has been emitted. A result waits in the output register,
// and a request already in flight stalls at its last step until that
// register is taken. Reset clears the accumulator and loads default config.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module motor_speed_pwm_integrator (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [15:0]        pulse_count,
	input  wire logic signed [15:0] target_rpm,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [9:0]              pwm_duty,
	output logic [15:0]             measured_rpm,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [15:0]        cfg_wdata
);

	logic [13:0] freq_q;
	logic [15:0] ppr_q;
	logic [2:0]  chan_q;
	logic [9:0]  gain_q;

	msp_pkg::msp_cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= msp_pkg::FREQ_RESET;
			ppr_q  <= msp_pkg::PPR_RESET;
			chan_q <= msp_pkg::CHAN_RESET;
			gain_q <= msp_pkg::GAIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				msp_pkg::REG_CONTROL_FREQUENCY:   freq_q <= cfg_wdata[13:0];
				msp_pkg::REG_PULSES_PER_ROTATION: ppr_q  <= cfg_wdata;
				msp_pkg::REG_CHANNEL_COUNT:       chan_q <= cfg_wdata[2:0];
				msp_pkg::REG_SPEED_GAIN:          gain_q <= cfg_wdata[9:0];
				default: ;
			endcase
		end
	end

	msp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	msp_dpath u_dpath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.pulse_count         (pulse_count),
		.target_rpm          (target_rpm),
		.control_frequency   (freq_q),
		.pulses_per_rotation (ppr_q),
		.channel_count       (chan_q),
		.speed_gain          (gain_q),
		.pwm_duty            (pwm_duty),
		.measured_rpm        (measured_rpm)
	);

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for motor_speed_pwm_integrator
// Drives control periods through the valid/ready request channel, keeps a
// shadow of the registers and the PWM accumulator, predicts duty and rpm for
// every accepted request and checks each result in order. Directed periods
// cover field extremes, clamping, zero divisors and register masking. Random
// traffic under several register settings and idle patterns follows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	localparam int CLK_PERIOD    = 20;
	localparam int SETTLE_CYCLES = 30;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int BLOCK_ITEMS   = 103;

	typedef struct {
		logic [9:0]  duty;
		logic [15:0] rpm;
	} duty_rpm_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [15:0]        pulse_count;
	logic signed [15:0] target_rpm;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [9:0]         pwm_duty;
	logic [15:0]        measured_rpm;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [15:0]        cfg_wdata;

	// shadow of the block's registers and accumulator
	logic [13:0] ctl_freq = msp_pkg::FREQ_RESET;
	logic [15:0] ppr      = msp_pkg::PPR_RESET;
	logic [2:0]  chan_cnt = msp_pkg::CHAN_RESET;
	logic [9:0]  gain     = msp_pkg::GAIN_RESET;
	logic [17:0] pwm_acc  = '0;

	duty_rpm_t duty_rpm_q[$];
	duty_rpm_t want;
	int        mismatch_count = 0;
	int        cycle_count = 0;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;

	motor_speed_pwm_integrator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pulse_count  (pulse_count),
		.target_rpm   (target_rpm),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pwm_duty     (pwm_duty),
		.measured_rpm (measured_rpm),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("motor_speed_pwm_integrator: mismatch");
			$finish;
		end
	end

	// Advance the shadow accumulator by one control period.
	function automatic duty_rpm_t predict_duty_and_rpm(logic [15:0] pulses,
			logic signed [15:0] target);
		longint unsigned num;
		longint unsigned den;
		longint unsigned quo;
		longint          sum;
		duty_rpm_t       r;
		num = 64'(pulses) * 64'd120 * 64'(ctl_freq);
		den = 64'(ppr) * 64'(chan_cnt);
		if (den == 0)
			quo = 64'(msp_pkg::RPM_MAX);
		else
			quo = num / den;
		if (quo > 64'(msp_pkg::RPM_MAX))
			quo = 64'(msp_pkg::RPM_MAX);
		sum = longint'(pwm_acc) + longint'(gain) * (longint'(target) - longint'(quo));
		if (sum > longint'(msp_pkg::ACC_MAX))
			sum = longint'(msp_pkg::ACC_MAX);
		if (sum < 0)
			sum = 0;
		pwm_acc = sum[17:0];
		r.duty = pwm_acc[17:8];
		r.rpm = quo[15:0];
		return r;
	endfunction

	// Check results in order; pick the receiver stall for the next cycle.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (duty_rpm_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual duty %0d rpm %0d",
					$time, pwm_duty, measured_rpm);
				mismatch_count++;
			end else begin
				want = duty_rpm_q.pop_front();
				if (pwm_duty !== want.duty) begin
					$display("%0t: pwm_duty expected %0d actual %0d",
						$time, want.duty, pwm_duty);
					mismatch_count++;
				end
				if (measured_rpm !== want.rpm) begin
					$display("%0t: measured_rpm expected %0d actual %0d",
						$time, want.rpm, measured_rpm);
					mismatch_count++;
				end
			end
		end
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	task automatic send_request(input logic [15:0] pulses, input logic signed [15:0] target);
		// idle the sender cycle by cycle before presenting the request
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pulse_count <= pulses;
		target_rpm <= target;
		do
			@(posedge clk);
		while (!in_ready);
		duty_rpm_q.push_back(predict_duty_and_rpm(pulses, target));
	endtask

	// Drop valid and hold until every result is back and the block is quiet.
	task automatic wait_idle;
		in_valid <= 1'b0;
		while (duty_rpm_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			msp_pkg::REG_CONTROL_FREQUENCY:   ctl_freq = data[13:0];
			msp_pkg::REG_PULSES_PER_ROTATION: ppr = data;
			msp_pkg::REG_CHANNEL_COUNT:       chan_cnt = data[2:0];
			msp_pkg::REG_SPEED_GAIN:          gain = data[9:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_defaults;
		write_register(msp_pkg::REG_CONTROL_FREQUENCY, 16'(msp_pkg::FREQ_RESET));
		write_register(msp_pkg::REG_PULSES_PER_ROTATION, msp_pkg::PPR_RESET);
		write_register(msp_pkg::REG_CHANNEL_COUNT, 16'(msp_pkg::CHAN_RESET));
		write_register(msp_pkg::REG_SPEED_GAIN, 16'(msp_pkg::GAIN_RESET));
	endtask

	task automatic load_random_config;
		logic [15:0] v;
		case ($urandom_range(0, 9))
			0: v = 16'd1;
			1: v = 16'd10000;
			2: v = 16'hFFFF;
			3: v = 16'd0;
			default: v = 16'($urandom_range(1, 10000));
		endcase
		write_register(msp_pkg::REG_CONTROL_FREQUENCY, v);
		case ($urandom_range(0, 9))
			0: v = 16'd1;
			1: v = 16'd65535;
			2: v = 16'd0;
			default: v = 16'($urandom_range(1, 4096));
		endcase
		write_register(msp_pkg::REG_PULSES_PER_ROTATION, v);
		case ($urandom_range(0, 7))
			0: v = 16'($urandom);
			1: v = 16'($urandom_range(0, 7));
			default: v = 16'($urandom_range(1, 4));
		endcase
		write_register(msp_pkg::REG_CHANNEL_COUNT, v);
		case ($urandom_range(0, 7))
			0: v = 16'd0;
			1: v = 16'd1023;
			2: v = 16'($urandom);
			default: v = 16'($urandom_range(0, 1023));
		endcase
		write_register(msp_pkg::REG_SPEED_GAIN, v);
	endtask

	// Reset settings: idle motor, clamp high, clamp low, rpm saturation.
	task automatic test_reset_defaults;
		send_request(16'd0, 16'sd0);
		send_request(16'd0, 16'sd32767);
		send_request(16'd0, 16'sd32767);
		send_request(16'd100, 16'sd1604);
		send_request(16'd0, -16'sd32768);
		send_request(16'd65535, 16'sd0);
		send_request(16'd65535, 16'sd32767);
		wait_idle();
	endtask

	// High bits of the write data must be dropped; frequency zero gives zero rpm.
	task automatic test_register_masking;
		write_register(msp_pkg::REG_CONTROL_FREQUENCY, 16'hFFFF);
		write_register(msp_pkg::REG_PULSES_PER_ROTATION, 16'd1);
		write_register(msp_pkg::REG_CHANNEL_COUNT, 16'hFFFF);
		write_register(msp_pkg::REG_SPEED_GAIN, 16'hFC01);
		send_request(16'd1, 16'sd100);
		send_request(16'd65535, -16'sd1);
		wait_idle();
		write_register(msp_pkg::REG_CONTROL_FREQUENCY, 16'd0);
		write_register(msp_pkg::REG_PULSES_PER_ROTATION, 16'd65535);
		write_register(msp_pkg::REG_SPEED_GAIN, 16'd1023);
		send_request(16'd65535, 16'sd500);
		send_request(16'd1, 16'sd500);
		wait_idle();
	endtask

	// Zero rotation count or zero channels makes the divider answer all ones.
	task automatic test_zero_divisor;
		load_defaults();
		write_register(msp_pkg::REG_PULSES_PER_ROTATION, 16'd0);
		send_request(16'd0, 16'sd0);
		send_request(16'd5, 16'sd32767);
		wait_idle();
		write_register(msp_pkg::REG_PULSES_PER_ROTATION, msp_pkg::PPR_RESET);
		write_register(msp_pkg::REG_CHANNEL_COUNT, 16'd0);
		send_request(16'd12, -16'sd5);
		wait_idle();
	endtask

	// Gain zero freezes the accumulator; full gain takes the largest steps.
	task automatic test_gain_extremes;
		load_defaults();
		send_request(16'd0, 16'sd300);
		wait_idle();
		write_register(msp_pkg::REG_SPEED_GAIN, 16'd0);
		send_request(16'd0, 16'sd32767);
		send_request(16'd65535, -16'sd32768);
		wait_idle();
		write_register(msp_pkg::REG_SPEED_GAIN, 16'd1023);
		send_request(16'd1, 16'sd20);
		send_request(16'd0, -16'sd1);
		send_request(16'd1, 16'sd128);
		wait_idle();
	endtask

	task automatic test_random_traffic;
		int                 phase;
		int                 blk;
		int                 n;
		int                 run_left;
		logic [15:0]        pulses;
		logic signed [15:0] target;
		logic signed [15:0] hold_target;
		hold_target = '0;
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 11;
					recv_idle_pct = 45;
				end
				1: begin
					send_idle_pct = 45;
					recv_idle_pct = 11;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (blk = 0; blk < 5; blk++) begin
				wait_idle();
				if (blk == 0 && phase == 0)
					load_defaults();
				else
					load_random_config();
				run_left = 0;
				for (n = 0; n < BLOCK_ITEMS; n++) begin
					// hold one setpoint over a run so the loop can settle
					if (run_left == 0) begin
						if ($urandom_range(0, 4) == 0)
							hold_target = 16'($urandom);
						else
							hold_target = 16'($urandom_range(0, 8000));
						run_left = $urandom_range(4, 40);
					end
					run_left--;
					if ($urandom_range(0, 7) == 0) begin
						pulses = 16'($urandom);
						target = 16'($urandom);
					end else begin
						case ($urandom_range(0, 3))
							0: pulses = 16'($urandom_range(0, 63));
							1: pulses = 16'($urandom_range(0, 1023));
							2: pulses = 16'($urandom_range(0, 8191));
							default: pulses = 16'($urandom);
						endcase
						target = hold_target;
					end
					send_request(pulses, target);
				end
			end
		end
		wait_idle();
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		pulse_count <= '0;
		target_rpm <= '0;
		cfg_we <= 1'b0;
		cfg_index <= msp_pkg::REG_CONTROL_FREQUENCY;
		cfg_wdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_register_masking();
		test_zero_divisor();
		test_gain_extremes();
		test_random_traffic();
		if (mismatch_count == 0)
			$display("motor_speed_pwm_integrator: match");
		else
			$display("motor_speed_pwm_integrator: mismatch");
		$finish;
	end

endmodule
